// File: hdl/atuab_pkg.sv
// ----------------------------------------------------------------------------
// atuab_pkg
// shared types, phase codes and character constants for the text to
// unsigned converter
// ----------------------------------------------------------------------------
package atuab_pkg;

    localparam int BASE_BITS = 6;
    localparam int CHAR_BITS = 8;
    localparam int OUT_BITS  = 32;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_SEEK  = 2'd1;
    localparam logic [1:0] PH_ZERO  = 2'd2;
    localparam logic [1:0] PH_SCAN  = 2'd3;

    localparam logic [BASE_BITS-1:0] BASE_NONE = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_BITS-1:0] NOT_DIGIT = 6'd63;

    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7a;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5a;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] LETTER_OFS = 8'd10;

    typedef struct packed {
        logic [1:0]           phase;
        logic [BASE_BITS-1:0] base;
    } parse_state_t;

    function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] t;
        begin
            t = {CHAR_BITS{1'b1}};
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                t = c - CH_ZERO;
            end
            else if (c >= CH_LA && c <= CH_LZ)
            begin
                t = c - CH_LA + LETTER_OFS;
            end
            else if (c >= CH_UA && c <= CH_UZ)
            begin
                t = c - CH_UA + LETTER_OFS;
            end
            if (t == {CHAR_BITS{1'b1}})
            begin
                digit_of = NOT_DIGIT;
            end
            else
            begin
                digit_of = t[BASE_BITS-1:0];
            end
        end
    endfunction

endpackage

// File: hdl/ascii_to_unsigned_auto_base_core.sv
// ----------------------------------------------------------------------------
// ascii_to_unsigned_auto_base_core
// streaming text to unsigned converter with automatic base detection
// ----------------------------------------------------------------------------
// the input stalls only while a finished word waits on a stalled output
// throughput: otherwise one character per cycle, set by the single
//   multiply-add of accumulator by base between input and state registers
// reset: asynchronous, clears the parse state, the base register and the
//   valid flags of both word registers at once; no clearing pass
module ascii_to_unsigned_auto_base_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] parsed_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);
    import atuab_pkg::*;

    logic                  hold_valid_reg, hold_valid_next;
    logic [CHAR_BITS-1:0]  char_reg;
    logic                  last_reg;
    logic [BASE_BITS-1:0]  base_sel_reg;
    parse_state_t          state_reg, state_next, step_state;
    logic [VALUE_BITS-1:0] acc_reg, acc_next, step_acc;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_value_reg;
    logic                  fire;
    logic                  in_take;

    atuab_step #(
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .state      (state_reg),
        .acc        (acc_reg),
        .char_code  (char_reg),
        .base_select(base_sel_reg),
        .state_next (step_state),
        .acc_next   (step_acc)
    );

    assign fire      = hold_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = hold_valid_reg && !fire;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign parsed_value = out_value_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (fire)
        begin
            hold_valid_next = 1'b0;
        end

        state_next = state_reg;
        acc_next   = acc_reg;
        if (fire)
        begin
            if (last_reg)
            begin
                state_next.phase = PH_START;
                state_next.base  = BASE_NONE;
                acc_next         = '0;
            end
            else
            begin
                state_next = step_state;
                acc_next   = step_acc;
            end
        end

        out_valid_next = out_valid_reg;
        if (fire && last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            base_sel_reg    <= BASE_NONE;
            state_reg.phase <= PH_START;
            state_reg.base  <= BASE_NONE;
            acc_reg         <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            if (cfg_valid && cfg_ready)
            begin
                base_sel_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_code;
            last_reg <= is_last;
        end
        if (fire && last_reg)
        begin
            out_value_reg <= OUT_BITS'(step_acc);
        end
    end

endmodule

// File: hdl/atuab_step.sv
// ----------------------------------------------------------------------------
// atuab_step
// next-state logic for one character: prefix handling, digit decode and
// the multiply-add of the accumulator
// ----------------------------------------------------------------------------
module atuab_step #(
    parameter int VALUE_BITS = 32
) (
    input  atuab_pkg::parse_state_t       state,
    input  logic [VALUE_BITS-1:0]         acc,
    input  logic [7:0]                    char_code,
    input  logic [5:0]                    base_select,
    output atuab_pkg::parse_state_t       state_next,
    output logic [VALUE_BITS-1:0]         acc_next
);
    import atuab_pkg::*;

    logic [BASE_BITS-1:0]  digit;
    logic [BASE_BITS-1:0]  eff_base;
    logic                  take;
    logic                  base_ok;
    logic [VALUE_BITS-1:0] acc_in;
    logic [VALUE_BITS-1:0] mac;
    logic                  is_zero;
    logic                  is_nz_dec;
    logic                  is_x;

    assign digit     = digit_of(char_code);
    assign is_zero   = (char_code == CH_ZERO);
    assign is_nz_dec = (char_code >= CH_ONE) && (char_code <= CH_NINE);
    assign is_x      = (char_code == CH_LX) || (char_code == CH_UX);
    assign acc_in    = (state.phase == PH_START) ? '0 : acc;

    always_comb
    begin
        state_next = state;
        eff_base   = state.base;
        take       = 1'b0;
        unique case (state.phase)
            PH_START:
            begin
                if (base_select != BASE_NONE)
                begin
                    state_next.base  = base_select;
                    state_next.phase = PH_SCAN;
                    eff_base         = base_select;
                    take             = 1'b1;
                end
                else
                begin
                    state_next.base = BASE_NONE;
                    if (is_zero)
                    begin
                        state_next.phase = PH_ZERO;
                    end
                    else if (is_nz_dec)
                    begin
                        state_next.base  = BASE_DEC;
                        state_next.phase = PH_SCAN;
                        eff_base         = BASE_DEC;
                        take             = 1'b1;
                    end
                    else
                    begin
                        state_next.phase = PH_SEEK;
                    end
                end
            end
            PH_SEEK:
            begin
                if (is_zero)
                begin
                    state_next.phase = PH_ZERO;
                end
                else if (is_nz_dec)
                begin
                    state_next.base  = BASE_DEC;
                    state_next.phase = PH_SCAN;
                    eff_base         = BASE_DEC;
                    take             = 1'b1;
                end
            end
            PH_ZERO:
            begin
                state_next.phase = PH_SCAN;
                if (is_x)
                begin
                    state_next.base = BASE_HEX;
                end
                else
                begin
                    state_next.base = BASE_OCT;
                    eff_base        = BASE_OCT;
                    take            = 1'b1;
                end
            end
            PH_SCAN:
            begin
                take = 1'b1;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    assign base_ok  = (eff_base >= BASE_MIN) && (eff_base <= BASE_MAX) && (digit < eff_base);
    assign mac      = acc_in * VALUE_BITS'(eff_base) + VALUE_BITS'(digit);
    assign acc_next = (take && base_ok) ? mac : acc_in;

endmodule
